FILE: sv/kpi_pkg.sv
// Shared types and constants for the keyframe plateau interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kpi_pkg;

    localparam int MAX_KEYS = 16;
    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int U_W = 16;
    localparam logic signed [17:0] PLATEAU_Q8 = 18'sd768;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } entry_t;

    // Search token that travels down the row of cells.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic signed [15:0] deg;
        entry_t             p;
        entry_t             q;
        entry_t             last;
    } tok_t;

endpackage
`default_nettype wire

FILE: sv/keyframe_plateau_interpolator_top.sv
// Top level of the keyframe plateau interpolator: handshakes, decision logic and lerp.
//
// Input stream (s_*): one transaction is either a keyframe load (tuser = 0) or an
// evaluate (tuser = 1). A load writes the entry into its cell and gives
// no result. An evaluate sends a search token down a row of sixteen cells, one cell
// per cycle; each cell checks whether the angle falls in its segment and the token
// also picks up the last keyframe on the way.
// Output stream (m_*): one transaction per evaluate with the x, y, z offsets.
// An evaluate passes through the cell row and then the decision state. When the
// result is a keyframe it goes straight on to the output register; when it
// interpolates it first passes through the divider steps, the flag on the quotient,
// the latched fraction, the products and the sum. A load leaves the block idle.
// One item is worked on at a time; the input is ready again as soon as the previous
// result sits in the output register. key_count is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, which the
// block itself does not enforce.
// Reset (aresetn low, synchronous) clears the count, the control state and the
// output valid; the keyframe table holds garbage until it is loaded.
// When the receiver stalls, the finished result waits in the output register and a
// following result waits in its last stage until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_plateau_interpolator_top import kpi_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,   // key_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // entry_index[3:0], angle, key_x, key_y, key_z, 4 zero bits
    input  wire logic [0:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // off_x, off_y, off_z
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_PROD = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [4:0]       count_reg;
    logic [CNT_W-1:0] key_n;
    logic             s_acc;
    entry_t           in_entry;
    tok_t             tok_first;
    tok_t             toks [MAX_KEYS+1];
    entry_t           owns [MAX_KEYS+1];
    tok_t             tok_end;

    // Decision path registers.
    entry_t           p_reg, q_reg;
    logic [U_W-1:0]   u_reg;
    logic signed [15:0] rx_reg, ry_reg, rz_reg;
    logic signed [15:0] rx_next, ry_next, rz_next;
    logic signed [33:0] prx_reg, pry_reg, prz_reg;
    logic             m_valid_reg;
    logic [47:0]      m_data_reg;

    logic             div_start, div_busy, div_done;
    logic [16:0]      div_num, div_den;
    logic [U_W-1:0]   div_quo;

    logic signed [17:0] pa, qb, pa0, qb0, deg18;
    logic               take_out;

    assign key_n    = (count_reg > 5'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(count_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign in_entry.angle = s_tdata[19:4];
    assign in_entry.x     = s_tdata[35:20];
    assign in_entry.y     = s_tdata[51:36];
    assign in_entry.z     = s_tdata[67:52];

    always_comb begin
        tok_first       = '0;
        tok_first.valid = s_acc && (s_tuser[0] == OP_EVAL);
        tok_first.deg   = s_tdata[19:4];
    end

    assign toks[0]        = tok_first;
    assign owns[MAX_KEYS] = '0;

    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        kpi_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .key_n    (key_n),
            .wr_en    (s_acc && (s_tuser[0] == OP_LOAD)),
            .wr_idx   (s_tdata[IDX_W-1:0]),
            .wr_entry (in_entry),
            .nbr      (owns[i+1]),
            .tok_in   (toks[i]),
            .own      (owns[i]),
            .tok_out  (toks[i+1])
        );
    end

    assign tok_end = toks[MAX_KEYS];

    // Plateau bounds of the segment that the token found.
    assign deg18 = 18'(tok_end.deg);
    assign pa0   = 18'(tok_end.p.angle) + PLATEAU_Q8;
    assign qb0   = 18'(tok_end.q.angle) - PLATEAU_Q8;
    always_comb begin
        if (qb0 <= pa0) begin
            pa = 18'(tok_end.p.angle);
            qb = 18'(tok_end.q.angle);
        end else begin
            pa = pa0;
            qb = qb0;
        end
    end
    assign div_num = 17'(deg18 - pa);
    assign div_den = 17'(qb - pa);

    kpi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign take_out = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rz_next    = rz_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_tuser[0] == OP_EVAL)) begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (tok_end.valid) begin
                    state_next = S_OUT;
                    if (key_n == '0) begin
                        rx_next = '0;
                        ry_next = '0;
                        rz_next = '0;
                    end else if (key_n == CNT_W'(1) || tok_end.deg <= owns[0].angle) begin
                        rx_next = owns[0].x;
                        ry_next = owns[0].y;
                        rz_next = owns[0].z;
                    end else if (tok_end.deg >= tok_end.last.angle || !tok_end.found) begin
                        rx_next = tok_end.last.x;
                        ry_next = tok_end.last.y;
                        rz_next = tok_end.last.z;
                    end else if (deg18 <= pa) begin
                        rx_next = tok_end.p.x;
                        ry_next = tok_end.p.y;
                        rz_next = tok_end.p.z;
                    end else if (deg18 >= qb) begin
                        rx_next = tok_end.q.x;
                        ry_next = tok_end.q.y;
                        rz_next = tok_end.q.z;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                // The products of the freshly latched fraction land at this edge.
                state_next = S_MUL;
            end
            S_MUL: begin
                rx_next    = 16'(p_reg.x + 16'(prx_reg >>> U_W));
                ry_next    = 16'(p_reg.y + 16'(pry_reg >>> U_W));
                rz_next    = 16'(p_reg.z + 16'(prz_reg >>> U_W));
                state_next = S_OUT;
            end
            S_OUT: begin
                if (take_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (state_reg == S_OUT && take_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        rz_reg <= rz_next;
        if (div_start) begin
            p_reg <= tok_end.p;
            q_reg <= tok_end.q;
        end
        if (div_done) begin
            u_reg <= div_quo;
        end
        // Products are formed in the cycle after the fraction is latched.
        prx_reg <= 34'((18'(q_reg.x) - 18'(p_reg.x)) * $signed({2'b00, u_reg}));
        pry_reg <= 34'((18'(q_reg.y) - 18'(p_reg.y)) * $signed({2'b00, u_reg}));
        prz_reg <= 34'((18'(q_reg.z) - 18'(p_reg.z)) * $signed({2'b00, u_reg}));
        if (state_reg == S_OUT && take_out) begin
            m_data_reg <= {rz_reg, ry_reg, rx_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The divider only runs while the sequencer waits for it.
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    // A search token only leaves the row while a search is pending.
    a_tok_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_end.valid |-> (state_reg == S_SRCH))
        else $error("search token out of step with the sequencer");

    // An accepted evaluate always starts a search.
    a_eval_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == OP_EVAL) |=> (state_reg == S_SRCH))
        else $error("evaluate accepted without a search");

endmodule
`default_nettype wire

FILE: sv/kpi_cell.sv
// One keyframe cell: stores an entry and checks the search token against its segment.
`timescale 1ns / 1ps
`default_nettype none
module kpi_cell import kpi_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire logic [CNT_W-1:0] key_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire entry_t           wr_entry,
    input  wire entry_t           nbr,
    input  wire tok_t             tok_in,
    output entry_t                own,
    output tok_t                  tok_out
);

    entry_t own_reg;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   has_seg;
    logic   hit;
    logic   is_last;

    assign has_seg = ({1'b0, cell_idx} + CNT_W'(1)) < key_n;
    assign is_last = {1'b0, cell_idx} == (key_n - CNT_W'(1));
    assign hit = tok_in.valid && !tok_in.found && has_seg
                 && (tok_in.deg >= own_reg.angle) && (tok_in.deg <= nbr.angle);

    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.found = 1'b1;
            tok_next.p     = own_reg;
            tok_next.q     = nbr;
        end
        if (is_last) begin
            tok_next.last = own_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == cell_idx)) begin
            own_reg <= wr_entry;
        end
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign own     = own_reg;
    assign tok_out = tok_reg;

endmodule
`default_nettype wire

FILE: sv/kpi_div.sv
// Restoring divider that forms the Q0.16 fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kpi_div import kpi_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [16:0]    num,
    input  wire logic [16:0]    den,
    output logic                busy,
    output logic                done,
    output logic [U_W-1:0]      quo
);

    logic [16:0]      rem_reg, rem_next;
    logic [16:0]      den_reg;
    logic [U_W-1:0]   quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [17:0]      r2;

    assign r2 = {rem_reg, 1'b0};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            quo_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (r2 >= {1'b0, den_reg}) begin
                rem_next = 17'(r2 - {1'b0, den_reg});
                quo_next = {quo_reg[U_W-2:0], 1'b1};
            end else begin
                rem_next = r2[16:0];
                quo_next = {quo_reg[U_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(U_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire
